[rtl/core/impt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the indexed max-priority table.
// No dependencies; every other file in rtl/core except impt_ram refers to this package.
package impt_pkg;

  // Fixed field widths of the command and result channels
  localparam int CMD_W  = 3;
  localparam int ID_W   = 6;
  localparam int PAY_W  = 32;
  localparam int PRIO_W = 16;
  localparam int STAT_W = 2;

  typedef logic [CMD_W-1:0]  impt_cmd_code_t;
  typedef logic [STAT_W-1:0] impt_status_t;

  localparam impt_cmd_code_t CMD_ADD      = 3'd0;
  localparam impt_cmd_code_t CMD_PROMOTE  = 3'd1;
  localparam impt_cmd_code_t CMD_GET_MAX  = 3'd2;
  localparam impt_cmd_code_t CMD_POP_MAX  = 3'd3;
  localparam impt_cmd_code_t CMD_IS_VALID = 3'd4;
  localparam impt_cmd_code_t CMD_GET      = 3'd5;

  localparam impt_status_t ST_OK    = 2'd0;
  localparam impt_status_t ST_FULL  = 2'd1;
  localparam impt_status_t ST_EMPTY = 2'd2;
  localparam impt_status_t ST_DEAD  = 2'd3;

  // Read address source for both memories
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_ID,
    RD_BEST
  } impt_rd_sel_t;

  // Which result gets captured into the result register
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_FULL,
    RES_ADD,
    RES_DEAD,
    RES_LOOK,
    RES_EMPTY,
    RES_MAX
  } impt_res_sel_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic          load;
    logic          add_wr;
    logic          promote_wr;
    logic          pop_wr;
    logic          scan_step;
    impt_rd_sel_t  rd_sel;
    logic          res_load;
    impt_res_sel_t res_sel;
    logic          out_load;
  } impt_ctrl_t;

  // Datapath -> controller status
  typedef struct packed {
    impt_cmd_code_t cmd;
    logic           full;
    logic           in_range;
    logic           live;
    logic           scan_done;
    logic           found;
  } impt_stat_t;

endpackage

[rtl/core/impt_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results.
// Depends on impt_pkg for the field widths.
interface impt_in_if;
  logic                       valid;
  logic                       ready;
  logic [impt_pkg::CMD_W-1:0] cmd;
  logic [impt_pkg::ID_W-1:0]  entry_id;
  logic [impt_pkg::PAY_W-1:0] payload_in;

  modport source (output valid, cmd, entry_id, payload_in, input ready);
  modport sink   (input valid, cmd, entry_id, payload_in, output ready);
endinterface

interface impt_out_if;
  logic                        valid;
  logic                        ready;
  logic [impt_pkg::ID_W-1:0]   result_id;
  logic [impt_pkg::PAY_W-1:0]  payload_out;
  logic [impt_pkg::PRIO_W-1:0] priority_out;
  logic                        is_live;
  logic [impt_pkg::STAT_W-1:0] status;

  modport source (output valid, result_id, payload_out, priority_out, is_live, status,
                  input ready);
  modport sink   (input valid, result_id, payload_out, priority_out, is_live, status,
                  output ready);
endinterface

[rtl/core/impt_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module impt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/impt_ctrl.sv]
`timescale 1ns / 1ps
// Command sequencer for the max-priority table: handshakes and step control.
// Depends on impt_pkg; drives impt_dp through impt_ctrl_t.
module impt_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  impt_pkg::impt_cmd_code_t in_cmd,
  input  logic                     out_ready,
  input  impt_pkg::impt_stat_t     stat,
  output logic                     in_ready,
  output logic                     out_valid,
  output impt_pkg::impt_ctrl_t     ctrl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_MAXRD  = 3'd5;
  localparam logic [2:0] S_MAXOUT = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    ctrl          = '0;
    ctrl.rd_sel   = impt_pkg::RD_SCAN;
    ctrl.res_sel  = impt_pkg::RES_ZERO;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          unique case (in_cmd) inside
            impt_pkg::CMD_ADD: state_nxt = S_ADD;
            impt_pkg::CMD_PROMOTE, impt_pkg::CMD_IS_VALID, impt_pkg::CMD_GET:
              state_nxt = S_LOOK;
            impt_pkg::CMD_GET_MAX, impt_pkg::CMD_POP_MAX: state_nxt = S_SCAN;
            default: begin
              ctrl.res_load = 1'b1;
              ctrl.res_sel  = impt_pkg::RES_ZERO;
              state_nxt     = S_EMIT;
            end
          endcase
        end
      end
      S_ADD: begin
        ctrl.res_load = 1'b1;
        if (stat.full) begin
          ctrl.res_sel = impt_pkg::RES_FULL;
        end else begin
          ctrl.add_wr  = 1'b1;
          ctrl.res_sel = impt_pkg::RES_ADD;
        end
        state_nxt = S_EMIT;
      end
      S_LOOK: begin
        ctrl.rd_sel = impt_pkg::RD_ID;
        if (!stat.in_range) begin
          ctrl.res_load = 1'b1;
          ctrl.res_sel  = impt_pkg::RES_DEAD;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        ctrl.res_load = 1'b1;
        if (!stat.live) begin
          ctrl.res_sel = impt_pkg::RES_DEAD;
        end else begin
          ctrl.res_sel    = impt_pkg::RES_LOOK;
          ctrl.promote_wr = (stat.cmd == impt_pkg::CMD_PROMOTE);
        end
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        ctrl.rd_sel    = impt_pkg::RD_SCAN;
        ctrl.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_MAXRD;
        end
      end
      S_MAXRD: begin
        ctrl.rd_sel = impt_pkg::RD_BEST;
        if (!stat.found) begin
          ctrl.res_load = 1'b1;
          ctrl.res_sel  = impt_pkg::RES_EMPTY;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_MAXOUT;
        end
      end
      S_MAXOUT: begin
        ctrl.res_load = 1'b1;
        ctrl.res_sel  = impt_pkg::RES_MAX;
        ctrl.pop_wr   = (stat.cmd == impt_pkg::CMD_POP_MAX);
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          ctrl.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/impt_dp.sv]
`timescale 1ns / 1ps
// Datapath: payload and priority memories, fill count, max scan, result regs.
// Depends on impt_pkg and impt_ram; steered by impt_ctrl.
module impt_dp #(
  parameter int MAX_ENTRIES    = 64,
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  impt_pkg::impt_ctrl_t            ctrl,
  input  impt_pkg::impt_cmd_code_t        in_cmd,
  input  logic [impt_pkg::ID_W-1:0]       in_entry_id,
  input  logic [impt_pkg::PAY_W-1:0]      in_payload,
  output impt_pkg::impt_stat_t            stat,
  output logic [impt_pkg::ID_W-1:0]       out_result_id,
  output logic [impt_pkg::PAY_W-1:0]      out_payload,
  output logic [impt_pkg::PRIO_W-1:0]     out_priority,
  output logic                            out_is_live,
  output impt_pkg::impt_status_t          out_status
);

  localparam int IDW = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int MW  = PRIORITY_WIDTH + 1;     // {live, priority}
  localparam int OIW = impt_pkg::ID_W;
  localparam int OPW = impt_pkg::PAY_W;
  localparam int OQW = impt_pkg::PRIO_W;

  // latched command
  impt_pkg::impt_cmd_code_t cmd_r;
  logic [OIW-1:0]           id_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;

  // fill count doubles as the "ever written" boundary
  logic [CW-1:0]             count_r;

  // scan state
  logic [CW-1:0]             sc_r;
  logic                      cmp_v_r;
  logic [IDW-1:0]            cmp_id_r;
  logic                      found_r;
  logic [IDW-1:0]            best_id_r;
  logic [PRIORITY_WIDTH-1:0] best_prio_r;

  // memory ports
  logic [IDW-1:0]           rd_addr;
  logic [IDW-1:0]           meta_wr_addr;
  logic [MW-1:0]            meta_wr_data;
  logic                     meta_wr_en;
  logic [MW-1:0]            meta_rd;
  logic [PAYLOAD_WIDTH-1:0] pay_rd;

  logic                      meta_live;
  logic [PRIORITY_WIDTH-1:0] meta_prio;
  logic [PRIORITY_WIDTH-1:0] prio_inc;
  logic [IDW-1:0]            id_addr;
  logic [IDW-1:0]            count_addr;

  // result staging and output registers
  logic [OIW-1:0]         res_id_r, res_id_nxt;
  logic [OPW-1:0]         res_pay_r, res_pay_nxt;
  logic [OQW-1:0]         res_prio_r, res_prio_nxt;
  logic                   res_live_r, res_live_nxt;
  impt_pkg::impt_status_t res_st_r, res_st_nxt;

  logic [OIW-1:0]         out_id_r;
  logic [OPW-1:0]         out_pay_r;
  logic [OQW-1:0]         out_prio_r;
  logic                   out_live_r;
  impt_pkg::impt_status_t out_st_r;

  assign meta_live  = meta_rd[PRIORITY_WIDTH];
  assign meta_prio  = meta_rd[PRIORITY_WIDTH-1:0];
  assign prio_inc   = (meta_prio == '1) ? meta_prio : meta_prio + PRIORITY_WIDTH'(1);
  assign id_addr    = IDW'(id_r);
  assign count_addr = count_r[IDW-1:0];

  always_comb begin
    case (ctrl.rd_sel)
      impt_pkg::RD_SCAN: rd_addr = sc_r[IDW-1:0];
      impt_pkg::RD_ID:   rd_addr = id_addr;
      impt_pkg::RD_BEST: rd_addr = best_id_r;
      default:           rd_addr = sc_r[IDW-1:0];
    endcase
  end

  always_comb begin
    meta_wr_en   = ctrl.add_wr || ctrl.promote_wr || ctrl.pop_wr;
    meta_wr_addr = count_addr;
    meta_wr_data = {1'b1, {PRIORITY_WIDTH{1'b0}}};
    if (ctrl.promote_wr) begin
      meta_wr_addr = id_addr;
      meta_wr_data = {1'b1, prio_inc};
    end else if (ctrl.pop_wr) begin
      meta_wr_addr = best_id_r;
      meta_wr_data = {1'b0, best_prio_r};
    end
  end

  impt_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (ctrl.add_wr),
    .wr_addr (count_addr),
    .wr_data (pay_r),
    .rd_addr (rd_addr),
    .rd_data (pay_rd)
  );

  impt_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_ENTRIES)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data),
    .rd_addr (rd_addr),
    .rd_data (meta_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sc_r    <= '0;
      cmp_v_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (ctrl.add_wr) begin
        count_r <= count_r + CW'(1);
      end
      if (ctrl.load) begin
        sc_r    <= '0;
        cmp_v_r <= 1'b0;
        found_r <= 1'b0;
      end else if (ctrl.scan_step) begin
        if (sc_r != count_r) begin
          sc_r    <= sc_r + CW'(1);
          cmp_v_r <= 1'b1;
        end else begin
          cmp_v_r <= 1'b0;
        end
        // >= while walking upward gives ties to the larger id
        if (cmp_v_r && meta_live && (!found_r || meta_prio >= best_prio_r)) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_cmd;
      id_r  <= in_entry_id;
      pay_r <= PAYLOAD_WIDTH'(in_payload);
    end
    if (ctrl.scan_step) begin
      cmp_id_r <= sc_r[IDW-1:0];
      if (cmp_v_r && meta_live && (!found_r || meta_prio >= best_prio_r)) begin
        best_id_r   <= cmp_id_r;
        best_prio_r <= meta_prio;
      end
    end
    if (ctrl.res_load) begin
      res_id_r   <= res_id_nxt;
      res_pay_r  <= res_pay_nxt;
      res_prio_r <= res_prio_nxt;
      res_live_r <= res_live_nxt;
      res_st_r   <= res_st_nxt;
    end
    if (ctrl.out_load) begin
      out_id_r   <= res_id_r;
      out_pay_r  <= res_pay_r;
      out_prio_r <= res_prio_r;
      out_live_r <= res_live_r;
      out_st_r   <= res_st_r;
    end
  end

  always_comb begin
    res_id_nxt   = '0;
    res_pay_nxt  = '0;
    res_prio_nxt = '0;
    res_live_nxt = 1'b0;
    res_st_nxt   = impt_pkg::ST_OK;
    unique case (ctrl.res_sel)
      impt_pkg::RES_ZERO: ;
      impt_pkg::RES_FULL:  res_st_nxt = impt_pkg::ST_FULL;
      impt_pkg::RES_EMPTY: res_st_nxt = impt_pkg::ST_EMPTY;
      impt_pkg::RES_ADD: begin
        res_id_nxt   = OIW'(count_r);
        res_pay_nxt  = OPW'(pay_r);
        res_live_nxt = 1'b1;
      end
      impt_pkg::RES_DEAD: begin
        res_id_nxt = id_r;
        res_st_nxt = impt_pkg::ST_DEAD;
      end
      impt_pkg::RES_LOOK: begin
        res_id_nxt   = id_r;
        res_pay_nxt  = OPW'(pay_rd);
        res_prio_nxt = (cmd_r == impt_pkg::CMD_PROMOTE) ? OQW'(prio_inc) : OQW'(meta_prio);
        res_live_nxt = 1'b1;
      end
      impt_pkg::RES_MAX: begin
        res_id_nxt   = OIW'(best_id_r);
        res_pay_nxt  = OPW'(pay_rd);
        res_prio_nxt = OQW'(best_prio_r);
        res_live_nxt = (cmd_r != impt_pkg::CMD_POP_MAX);
      end
      default: ;
    endcase
  end

  assign stat.cmd       = cmd_r;
  assign stat.full      = (count_r == CW'(MAX_ENTRIES));
  assign stat.in_range  = (32'(id_r) < 32'(count_r));
  assign stat.live      = meta_live;
  assign stat.scan_done = (sc_r == count_r) && !cmp_v_r;
  assign stat.found     = found_r;

  assign out_result_id = out_id_r;
  assign out_payload   = out_pay_r;
  assign out_priority  = out_prio_r;
  assign out_is_live   = out_live_r;
  assign out_status    = out_st_r;

endmodule

[rtl/core/indexed_max_priority_table.sv]
`timescale 1ns / 1ps
// Indexed max-priority table: add, promote, get/pop max, is-valid and get by id.
// One command in flight at a time; one result per command. Get-max and pop-max
// scan all ids handed out so far: a single comparator walks the priority memory
// one entry per cycle through its one read port. A finished result sits in an
// output register; the next command can only start once that result has moved
// into it. No clearing pass after reset: the fill count marks written entries.
// Depends on impt_pkg, impt_if, impt_ram, impt_ctrl and impt_dp.
module indexed_max_priority_table #(
  parameter int MAX_ENTRIES    = 64,
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  impt_in_if.sink    in_ch,
  impt_out_if.source out_ch
);

  impt_pkg::impt_ctrl_t ctrl;
  impt_pkg::impt_stat_t stat;
  logic                 in_ready;
  logic                 out_valid;

  impt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  impt_dp #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_cmd        (in_ch.cmd),
    .in_entry_id   (in_ch.entry_id),
    .in_payload    (in_ch.payload_in),
    .stat          (stat),
    .out_result_id (out_ch.result_id),
    .out_payload   (out_ch.payload_out),
    .out_priority  (out_ch.priority_out),
    .out_is_live   (out_ch.is_live),
    .out_status    (out_ch.status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // one command at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("command accepted while another was in flight");

  // ids are never reused, so a full table stays full
  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |=> stat.full)
    else $error("fill count went back down");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == impt_pkg::ST_FULL) |-> stat.full)
    else $error("table-full status reported while table not full");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for indexed_max_priority_table: directed and random commands.
// Depends on impt_pkg and impt_if from rtl/core and on the DUT itself.
module testbench;

  localparam int NUM_IDS    = 64;
  localparam int IDLE_LIMIT = 3000;
  localparam int RAND_CMDS  = 600;
  localparam int HOLD_LEN   = 400;
  localparam logic [impt_pkg::PRIO_W-1:0] PRIO_TOP = {impt_pkg::PRIO_W{1'b1}};
  // codes with no operation behind them
  localparam impt_pkg::impt_cmd_code_t CMD_RSVD6 = 3'd6;
  localparam impt_pkg::impt_cmd_code_t CMD_RSVD7 = 3'd7;

  typedef struct packed {
    logic [impt_pkg::ID_W-1:0]   rid;
    logic [impt_pkg::PAY_W-1:0]  pay;
    logic [impt_pkg::PRIO_W-1:0] prio;
    logic                        live;
    impt_pkg::impt_status_t      status;
  } entry_report_t;

  class prio_table_scoreboard;
    logic [impt_pkg::PAY_W-1:0]  payload_mem [NUM_IDS];
    logic [impt_pkg::PRIO_W-1:0] prio_mem [NUM_IDS];
    bit                          live_mem [NUM_IDS];
    int unsigned                 next_id;
    entry_report_t               pending [$];
    int                          errors;
    int                          commands;
    int                          results;
    int                          status_hits [4];

    function new();
      next_id = 0;
      foreach (live_mem[i]) live_mem[i] = 1'b0;
      errors = 0;
      commands = 0;
      results = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int num_live();
      int n;
      n = 0;
      foreach (live_mem[i]) n += live_mem[i];
      return n;
    endfunction

    // highest priority wins; a tie goes to the larger id
    function bit find_best(output int unsigned best);
      bit found;
      found = 1'b0;
      best = 0;
      for (int i = 0; i < NUM_IDS; i++) begin
        if (live_mem[i] && (!found || prio_mem[i] >= prio_mem[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      return found;
    endfunction

    function void note_command(impt_pkg::impt_cmd_code_t cmd,
                               logic [impt_pkg::ID_W-1:0] id,
                               logic [impt_pkg::PAY_W-1:0] pay);
      entry_report_t r;
      int unsigned   best;
      r = '0;
      commands++;
      case (cmd) inside
        impt_pkg::CMD_ADD: begin
          if (next_id >= NUM_IDS) begin
            r.status = impt_pkg::ST_FULL;
          end else begin
            payload_mem[next_id] = pay;
            prio_mem[next_id]    = '0;
            live_mem[next_id]    = 1'b1;
            r.rid    = next_id[impt_pkg::ID_W-1:0];
            r.pay    = pay;
            r.live   = 1'b1;
            r.status = impt_pkg::ST_OK;
            next_id++;
          end
        end
        impt_pkg::CMD_PROMOTE, impt_pkg::CMD_IS_VALID, impt_pkg::CMD_GET: begin
          r.rid = id;
          if (!live_mem[id]) begin
            r.status = impt_pkg::ST_DEAD;
          end else begin
            if (cmd == impt_pkg::CMD_PROMOTE && prio_mem[id] != PRIO_TOP) prio_mem[id]++;
            r.pay    = payload_mem[id];
            r.prio   = prio_mem[id];
            r.live   = 1'b1;
            r.status = impt_pkg::ST_OK;
          end
        end
        impt_pkg::CMD_GET_MAX, impt_pkg::CMD_POP_MAX: begin
          if (!find_best(best)) begin
            r.status = impt_pkg::ST_EMPTY;
          end else begin
            if (cmd == impt_pkg::CMD_POP_MAX) live_mem[best] = 1'b0;
            r.rid    = best[impt_pkg::ID_W-1:0];
            r.pay    = payload_mem[best];
            r.prio   = prio_mem[best];
            r.live   = (cmd != impt_pkg::CMD_POP_MAX);
            r.status = impt_pkg::ST_OK;
          end
        end
        default: r = '0;
      endcase
      status_hits[r.status]++;
      pending = {pending, r};
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      if (errors < 40)
        $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(entry_report_t got);
      entry_report_t want;
      results++;
      if (pending.size() == 0) begin
        report("result with nothing pending", 64'(got.rid), '0);
        return;
      end
      want = pending.pop_front();
      if (got.rid !== want.rid) report("result_id", 64'(got.rid), 64'(want.rid));
      if (got.pay !== want.pay) report("payload_out", 64'(got.pay), 64'(want.pay));
      if (got.prio !== want.prio) report("priority_out", 64'(got.prio), 64'(want.prio));
      if (got.live !== want.live) report("is_live", 64'(got.live), 64'(want.live));
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  bit   hold_req;
  int   idle_cycles = 0;

  impt_in_if  in_ch ();
  impt_out_if out_ch ();

  prio_table_scoreboard sb = new();

  indexed_max_priority_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [impt_pkg::ID_W-1:0] rand_id();
    logic [31:0] v;
    v = $urandom;
    return v[impt_pkg::ID_W-1:0];
  endfunction

  task automatic send_cmd(input impt_pkg::impt_cmd_code_t cmd,
                          input logic [impt_pkg::ID_W-1:0] id,
                          input logic [impt_pkg::PAY_W-1:0] pay);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.entry_id   <= id;
    in_ch.payload_in <= pay;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(cmd, id, pay);
  endtask

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    int stall_left;
    bit hold_done;
    entry_report_t got;
    stall_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.rid    = out_ch.result_id;
        got.pay    = out_ch.payload_out;
        got.prio   = out_ch.priority_out;
        got.live   = out_ch.is_live;
        got.status = out_ch.status;
        sb.check_result(got);
      end
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    impt_pkg::impt_cmd_code_t   cmd;
    logic [impt_pkg::ID_W-1:0]  id;
    int unsigned                id_sel;
    int                         r;
    int                         pick;
    rst_n            = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = impt_pkg::CMD_ADD;
    in_ch.entry_id   = '0;
    in_ch.payload_in = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unassigned ids, reserved codes
    send_cmd(impt_pkg::CMD_GET_MAX, rand_id(), $urandom);
    send_cmd(impt_pkg::CMD_POP_MAX, rand_id(), $urandom);
    send_cmd(impt_pkg::CMD_IS_VALID, 6'd0, $urandom);
    send_cmd(impt_pkg::CMD_GET, 6'd63, $urandom);
    send_cmd(impt_pkg::CMD_PROMOTE, 6'd5, $urandom);
    send_cmd(CMD_RSVD6, 6'd63, 32'hFFFF_FFFF);
    send_cmd(CMD_RSVD7, 6'd42, 32'h1234_5678);
    // payload extremes, then ties and promotions
    send_cmd(impt_pkg::CMD_ADD, 6'd63, 32'h0000_0000);
    send_cmd(impt_pkg::CMD_ADD, 6'd0, 32'hFFFF_FFFF);
    send_cmd(impt_pkg::CMD_ADD, 6'd21, 32'hA5A5_5A5A);
    send_cmd(impt_pkg::CMD_GET_MAX, rand_id(), $urandom);
    send_cmd(impt_pkg::CMD_PROMOTE, 6'd0, $urandom);
    send_cmd(impt_pkg::CMD_PROMOTE, 6'd0, $urandom);
    send_cmd(impt_pkg::CMD_GET_MAX, rand_id(), $urandom);
    send_cmd(impt_pkg::CMD_PROMOTE, 6'd1, $urandom);
    send_cmd(impt_pkg::CMD_PROMOTE, 6'd1, $urandom);
    send_cmd(impt_pkg::CMD_IS_VALID, 6'd1, $urandom);
    send_cmd(impt_pkg::CMD_GET, 6'd0, $urandom);
    send_cmd(impt_pkg::CMD_POP_MAX, rand_id(), $urandom);
    // popped id is dead from now on
    send_cmd(impt_pkg::CMD_GET, 6'd1, $urandom);
    send_cmd(impt_pkg::CMD_PROMOTE, 6'd1, $urandom);
    send_cmd(impt_pkg::CMD_IS_VALID, 6'd1, $urandom);
    send_cmd(impt_pkg::CMD_POP_MAX, rand_id(), $urandom);
    send_cmd(impt_pkg::CMD_POP_MAX, rand_id(), $urandom);
    send_cmd(impt_pkg::CMD_GET_MAX, rand_id(), $urandom);

    // back-to-back promotes on a fresh entry
    calm = 1'b1;
    send_cmd(impt_pkg::CMD_ADD, rand_id(), $urandom);
    repeat (8) send_cmd(impt_pkg::CMD_PROMOTE, 6'd3, $urandom);
    send_cmd(impt_pkg::CMD_GET, 6'd3, $urandom);
    calm = 1'b0;

    for (int n = 0; n < RAND_CMDS; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 100) begin
        calm     = 1'b0;
        hold_req = 1'b1;
      end
      // mostly address live entries so promotes and lookups hit
      id_sel = $urandom_range(0, NUM_IDS - 1);
      if (sb.num_live() > 0 && $urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, sb.num_live() - 1);
        foreach (sb.live_mem[i]) begin
          if (sb.live_mem[i]) begin
            if (pick == 0) id_sel = i;
            pick--;
          end
        end
      end
      id = id_sel[impt_pkg::ID_W-1:0];
      r = $urandom_range(0, 99);
      if (r < 15) cmd = impt_pkg::CMD_ADD;
      else if (r < 45) cmd = impt_pkg::CMD_PROMOTE;
      else if (r < 55) cmd = impt_pkg::CMD_IS_VALID;
      else if (r < 65) cmd = impt_pkg::CMD_GET;
      else if (r < 80) cmd = impt_pkg::CMD_GET_MAX;
      else if (r < 94 && (r < 88 || sb.next_id >= NUM_IDS)) cmd = impt_pkg::CMD_POP_MAX;
      else if (r < 94) cmd = impt_pkg::CMD_GET_MAX;
      else cmd = ($urandom_range(0, 1) != 0) ? CMD_RSVD6 : CMD_RSVD7;
      send_cmd(cmd, id, $urandom);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report("results still outstanding", 64'(sb.pending.size()), '0);

    $display("Ran %0d commands, checked %0d results; %0d mismatches.",
             sb.commands, sb.results, sb.errors);
    $display("Status mix ok/full/empty/dead: %0d/%0d/%0d/%0d.",
             sb.status_hits[impt_pkg::ST_OK], sb.status_hits[impt_pkg::ST_FULL],
             sb.status_hits[impt_pkg::ST_EMPTY], sb.status_hits[impt_pkg::ST_DEAD]);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
